FILE: rtl/bounded_deque_with_search_core_assert.svh
// Assertion macros shared by the deque core.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BDQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque core: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque core: next-cycle check failed");

`endif

FILE: rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int WORD_W = 32;

    // Transaction action codes
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SEARCH     = 3'd4
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_UNDERFLOW = 2'd2,
        STS_NOTFOUND  = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    // Command broadcast to the cell row
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD_AT,
        OP_PUSH_FRONT,
        OP_ROTATE
    } t_chain_op;

    // Per-cell control
    typedef struct packed {
        logic load;
        logic from_prev;
        logic from_next;
    } t_cell_ctl;

endpackage

FILE: rtl/bdq_cell.sv
module bdq_cell
    import bdq_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [WORD_W-1:0] i_load_value,
    input  logic [WORD_W-1:0] i_prev,
    input  logic [WORD_W-1:0] i_next,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    // Load wins over a shift; otherwise hold
    always_comb begin
        n_word = r_word;
        if (i_ctl.load) begin
            n_word = i_load_value;
        end else if (i_ctl.from_prev) begin
            n_word = i_prev;
        end else if (i_ctl.from_next) begin
            n_word = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: rtl/bdq_chain.sv
module bdq_chain
    import bdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  t_chain_op                i_op,
    input  logic [$clog2(DEPTH)-1:0] i_idx,
    input  logic [WORD_W-1:0]        i_value,
    output logic [WORD_W-1:0]        o_head
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [WORD_W-1:0] word [DEPTH];

    // Build the ring: cell 0 is the front, the last cell wraps to cell 0
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_cell_ctl ctl;

        always_comb begin
            ctl.load      = ((i_op == OP_LOAD_AT) && (i_idx == IDX_W'(k))) ||
                            ((i_op == OP_PUSH_FRONT) && (k == 0));
            ctl.from_prev = (i_op == OP_PUSH_FRONT);
            ctl.from_next = (i_op == OP_ROTATE);
        end

        bdq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_load_value (i_value),
            .i_prev       (word[(k + DEPTH - 1) % DEPTH]),
            .i_next       (word[(k + 1) % DEPTH]),
            .o_word       (word[k])
        );
    end

    assign o_head = word[0];

endmodule

FILE: rtl/bounded_deque_with_search_core.sv
// Bounded double-ended queue of 32-bit words with search by value. The words
// sit in a ring of DEPTH cells, front in cell 0. A transaction is taken when
// start is high and busy is low; every transaction gives exactly one result,
// shown for one cycle with o_valid, in the cycle after the work ends, and the
// receiver cannot stall it. Pushes, pops and ignored action codes finish in
// the accept cycle, so a new transaction may follow in the very next cycle.
// A search on a non-empty queue rotates the ring by one cell per cycle while
// comparing the front cell, one full turn in all, which restores the order;
// busy is high for the whole scan and the result appears right after.
`include "bounded_deque_with_search_core_assert.svh"

module bounded_deque_with_search_core
    import bdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 i_action,
    input  logic signed [WORD_W-1:0]   i_value,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_position,
    output logic [$clog2(DEPTH+1)-1:0] o_occupancy
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_step, n_step;
    logic              r_found, n_found;
    logic [CNT_W-1:0]  r_hit_pos, n_hit_pos;
    logic [WORD_W-1:0] r_key, n_key;
    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [CNT_W-1:0]  r_position, n_position;
    logic [CNT_W-1:0]  r_occupancy, n_occupancy;

    t_chain_op         chain_op;
    logic [IDX_W-1:0]  chain_idx;
    logic [WORD_W-1:0] head;
    logic              match;
    logic [CNT_W-1:0]  step_pos;

    bdq_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_op    (chain_op),
        .i_idx   (chain_idx),
        .i_value (i_value),
        .o_head  (head)
    );

    // Compare the front cell during the scan
    assign step_pos = CNT_W'(r_step) + CNT_W'(1);
    assign match    = (head == r_key) && (CNT_W'(r_step) < r_count) && !r_found;

    // Next state, chain command and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_found     = r_found;
        n_hit_pos   = r_hit_pos;
        n_key       = r_key;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_position  = r_position;
        n_occupancy = r_occupancy;
        chain_op    = OP_HOLD;
        chain_idx   = r_count[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_valid    = 1'b1;
                    n_status   = STS_DONE;
                    n_position = '0;
                    case (i_action)
                        ACT_PUSH_FRONT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = STS_OVERFLOW;
                            end else begin
                                chain_op = OP_PUSH_FRONT;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        ACT_PUSH_BACK: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = STS_OVERFLOW;
                            end else begin
                                chain_op = OP_LOAD_AT;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = STS_UNDERFLOW;
                            end else begin
                                chain_op = OP_ROTATE;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        ACT_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = STS_UNDERFLOW;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        ACT_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = STS_UNDERFLOW;
                            end else begin
                                n_valid   = 1'b0;
                                n_state   = ST_SEARCH;
                                n_key     = i_value;
                                n_step    = '0;
                                n_found   = 1'b0;
                                n_hit_pos = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_occupancy = n_count;
                end
            end
            ST_SEARCH: begin
                // Advance the ring one cell per cycle, one full turn
                chain_op = OP_ROTATE;
                if (match) begin
                    n_found   = 1'b1;
                    n_hit_pos = step_pos;
                end
                if (r_step == IDX_W'(DEPTH - 1)) begin
                    n_state     = ST_IDLE;
                    n_valid     = 1'b1;
                    n_occupancy = r_count;
                    if (r_found) begin
                        n_status   = STS_DONE;
                        n_position = r_hit_pos;
                    end else if (match) begin
                        n_status   = STS_DONE;
                        n_position = step_pos;
                    end else begin
                        n_status   = STS_NOTFOUND;
                        n_position = '0;
                    end
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_found <= n_found;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hit_pos   <= n_hit_pos;
        r_key       <= n_key;
        r_status    <= n_status;
        r_position  <= n_position;
        r_occupancy <= n_occupancy;
    end

    assign busy        = (r_state == ST_SEARCH);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;
    assign o_occupancy = r_occupancy;

    // Checks
    `BDQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `BDQ_ASSERT_NEXT(a_quick_result, i_clk, i_rst_n,
        start && !busy && (i_action != ACT_SEARCH), o_valid && !busy)
    `BDQ_ASSERT_NEXT(a_scan_holds, i_clk, i_rst_n,
        busy && (r_step != IDX_W'(DEPTH - 1)), busy && !o_valid)
    `BDQ_ASSERT_SAME(a_occupancy_match, i_clk, i_rst_n, o_valid, o_occupancy == r_count)

endmodule
